### rtl/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg: shared types and constants for the double-ended queue
// Command and status codes, beat payloads and the per-cell control word.
// ----------------------------------------------------------------------------
package dq_pkg;

	localparam int DEPTH  = 16;
	localparam int WORD_W = 32;
	localparam int CNT_W  = $clog2(DEPTH + 1);

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	// command codes; code seven has no meaning and is ignored
	typedef enum logic [2:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_BACK  = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_BACK   = 3'd3,
		CMD_PEEK_FRONT = 3'd4,
		CMD_PEEK_BACK  = 3'd5,
		CMD_CLEAR      = 3'd6
	} cmd_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic [2:0] command;
		word_t      data_in;
	} dq_in_t;

	typedef struct packed {
		word_t      data_out;
		logic [1:0] status;
		cnt_t       count;
	} dq_out_t;

	// operation broadcast to every cell of the chain
	typedef enum logic [2:0] {
		OP_HOLD,
		OP_SHIFT_IN,   // push front: every word moves one cell toward the back
		OP_SHIFT_OUT,  // pop front: every word moves one cell toward the front
		OP_LOAD_TAIL,  // push back: first free cell takes the word
		OP_DROP_TAIL,  // pop back: last held cell goes empty
		OP_CLEAR
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		word_t    push_word;
	} cell_ctl_t;

endpackage

### rtl/double_ended_queue_core.sv
// ----------------------------------------------------------------------------
// double_ended_queue_core: bounded double-ended queue of 32-bit words
// A chain of DEPTH cells with the front word in the first cell.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries a command and a word.
//   Output channel (out_valid/out_ready/out_data) returns one beat per input
//   beat: the popped or peeked word, a status and the count after the command.
//   Every command is executed in the cycle it is accepted; all cells shift,
//   load or drop in parallel, so the result beat appears in the cycle after
//   acceptance; while out_ready is high one command is taken every cycle.
//   The back word is picked by a one-hot OR over the cells' tail outputs.
//   The result sits in an output register; a new command is accepted while
//   that register is empty or being drained in the same cycle. When the
//   receiver stalls, the result holds and in_ready drops until it is taken.
//   Reset empties the queue and the output register at once; no sweep.
//   Pop or peek on an empty queue returns zero with status empty, a push on a
//   full queue is dropped with status full, clear empties every cell together.
// ----------------------------------------------------------------------------
module double_ended_queue_core
	import dq_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  dq_in_t  in_data,
	output logic    out_valid,
	input  logic    out_ready,
	output dq_out_t out_data
);

	word_t      cell_word [DEPTH];
	word_t      cell_tail [DEPTH];
	logic [DEPTH-1:0] cell_occ;

	cell_ctl_t  ctl;
	logic       in_fire;
	logic       empty;
	logic       full;
	word_t      tail_word;
	cnt_t       held_q;
	cnt_t       held_nxt;
	dq_out_t    res;
	dq_out_t    out_q;
	logic       out_valid_q;

	assign in_fire  = in_valid && in_ready;
	assign in_ready = !out_valid_q || out_ready;
	assign empty    = !cell_occ[0];
	assign full     = cell_occ[DEPTH-1];

	// back word: only the tail cell drives nonzero
	always_comb begin
		tail_word = '0;
		for (int i = 0; i < DEPTH; i++) begin
			tail_word = tail_word | cell_tail[i];
		end
	end

	// command decode
	always_comb begin
		ctl.op        = OP_HOLD;
		ctl.push_word = in_data.data_in;
		res.data_out  = '0;
		res.status    = ST_DONE;
		held_nxt      = held_q;
		case (in_data.command)
			CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
				if (full) begin
					res.status = ST_FULL;
				end else begin
					ctl.op   = (in_data.command == CMD_PUSH_FRONT) ? OP_SHIFT_IN
						: OP_LOAD_TAIL;
					held_nxt = held_q + cnt_t'(1);
				end
			end
			CMD_POP_FRONT, CMD_PEEK_FRONT: begin
				if (empty) begin
					res.status = ST_EMPTY;
				end else begin
					res.data_out = cell_word[0];
					if (in_data.command == CMD_POP_FRONT) begin
						ctl.op   = OP_SHIFT_OUT;
						held_nxt = held_q - cnt_t'(1);
					end
				end
			end
			CMD_POP_BACK, CMD_PEEK_BACK: begin
				if (empty) begin
					res.status = ST_EMPTY;
				end else begin
					res.data_out = tail_word;
					if (in_data.command == CMD_POP_BACK) begin
						ctl.op   = OP_DROP_TAIL;
						held_nxt = held_q - cnt_t'(1);
					end
				end
			end
			CMD_CLEAR: begin
				ctl.op   = OP_CLEAR;
				held_nxt = '0;
			end
			default: ;
		endcase
		res.count = held_nxt;
		if (!in_fire) begin
			ctl.op = OP_HOLD;
		end
	end

	// cell chain
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		word_t l_word, r_word;
		logic  l_occ, r_occ;
		if (i == 0) begin : g_head
			assign l_word = in_data.data_in;
			assign l_occ  = 1'b1;
		end else begin : g_mid_l
			assign l_word = cell_word[i-1];
			assign l_occ  = cell_occ[i-1];
		end
		if (i == DEPTH - 1) begin : g_end
			assign r_word = '0;
			assign r_occ  = 1'b0;
		end else begin : g_mid_r
			assign r_word = cell_word[i+1];
			assign r_occ  = cell_occ[i+1];
		end
		dq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.left_word  (l_word),
			.left_occ   (l_occ),
			.right_word (r_word),
			.right_occ  (r_occ),
			.word       (cell_word[i]),
			.occ        (cell_occ[i]),
			.tail_word  (cell_tail[i])
		);
	end

	// count and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				held_q <= held_nxt;
			end
			if (in_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_count_matches_cells: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(cell_occ) == int'(held_q))
		else $error("held count disagrees with occupied cells");

	a_head_occ: assert property (@(posedge clk) disable iff (!arst_n)
		(held_q == '0) == !cell_occ[0])
		else $error("front cell occupancy disagrees with count");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && in_data.command == CMD_CLEAR) |=> (held_q == '0 && cell_occ == '0))
		else $error("clear left words behind");

	a_result_count: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (out_valid_q && out_q.count == held_q))
		else $error("result count differs from held count");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && full && (in_data.command == CMD_PUSH_FRONT
			|| in_data.command == CMD_PUSH_BACK)) |=> $stable(held_q))
		else $error("push on full queue changed the count");

endmodule

### rtl/dq_cell.sv
// ----------------------------------------------------------------------------
// dq_cell: one slot of the queue chain
// Holds one word and an occupied flag; moves data to and from its neighbors.
// ----------------------------------------------------------------------------
module dq_cell
	import dq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  word_t     left_word,
	input  logic      left_occ,
	input  word_t     right_word,
	input  logic      right_occ,
	output word_t     word,
	output logic      occ,
	output word_t     tail_word
);

	word_t word_q;
	logic  occ_q;
	logic  is_tail;
	logic  is_free_head;

	assign is_tail      = occ_q && !right_occ;
	assign is_free_head = !occ_q && left_occ;

	// occupancy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else begin
			case (ctl.op)
				OP_SHIFT_IN:  occ_q <= left_occ;
				OP_SHIFT_OUT: occ_q <= right_occ;
				OP_LOAD_TAIL: if (is_free_head) occ_q <= 1'b1;
				OP_DROP_TAIL: if (is_tail) occ_q <= 1'b0;
				OP_CLEAR:     occ_q <= 1'b0;
				default:      occ_q <= occ_q;
			endcase
		end
	end

	// data word, no reset needed
	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_SHIFT_IN:  word_q <= left_word;
			OP_SHIFT_OUT: word_q <= right_word;
			OP_LOAD_TAIL: if (is_free_head) word_q <= ctl.push_word;
			default:      word_q <= word_q;
		endcase
	end

	assign word      = word_q;
	assign occ       = occ_q;
	assign tail_word = is_tail ? word_q : '0;

endmodule

### verif/double_ended_queue_core_test.sv
// ----------------------------------------------------------------------------
// double_ended_queue_core_test: self-checking bench for the deque core
// Drives command beats through the valid/ready input channel, predicts every
// result beat with a ring-store model of the queue and compares each field.
// Both channels idle in random bursts; the queue is swept from empty to full.
// ----------------------------------------------------------------------------
module double_ended_queue_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import dq_pkg::*;

	localparam int         IDX_W      = $clog2(DEPTH);
	localparam logic [2:0] CMD_UNUSED = 3'd7;   // code seven: ignored by the core
	localparam int         MAX_REPORT = 10;

	// ring-store model of the queue plus the line of results still owed
	class deque_scoreboard;
		word_t            ring [DEPTH];
		logic [IDX_W-1:0] head;
		cnt_t             fill;
		dq_out_t          awaited [$];
		int               faults;
		int               seen_cmd [8];
		int               seen_full;
		int               seen_empty;

		function new();
			head       = '0;
			fill       = '0;
			faults     = 0;
			seen_full  = 0;
			seen_empty = 0;
			foreach (ring[i]) ring[i] = '0;
			foreach (seen_cmd[i]) seen_cmd[i] = 0;
		endfunction

		function logic [IDX_W-1:0] slot_at(int offset);
			return IDX_W'((int'(head) + offset) % DEPTH);
		endfunction

		// accepted command beat: update the model and queue up its result
		function void note_command(dq_in_t beat);
			dq_out_t want;
			want = '0;
			seen_cmd[beat.command]++;
			case (beat.command)
				CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
					if (fill >= DEPTH) begin
						want.status = ST_FULL;
						seen_full++;
					end else if (beat.command == CMD_PUSH_FRONT) begin
						head       = slot_at(DEPTH - 1);
						ring[head] = beat.data_in;
						fill       = fill + 1'b1;
					end else begin
						ring[slot_at(int'(fill))] = beat.data_in;
						fill                      = fill + 1'b1;
					end
				end
				CMD_POP_FRONT, CMD_PEEK_FRONT: begin
					if (fill == 0) begin
						want.status = ST_EMPTY;
						seen_empty++;
					end else begin
						want.data_out = ring[head];
						if (beat.command == CMD_POP_FRONT) begin
							head = slot_at(1);
							fill = fill - 1'b1;
						end
					end
				end
				CMD_POP_BACK, CMD_PEEK_BACK: begin
					if (fill == 0) begin
						want.status = ST_EMPTY;
						seen_empty++;
					end else begin
						want.data_out = ring[slot_at(int'(fill) - 1)];
						if (beat.command == CMD_POP_BACK) fill = fill - 1'b1;
					end
				end
				CMD_CLEAR: begin
					fill = '0;   // front index is kept
				end
				default: begin
				end
			endcase
			want.count = fill;
			awaited.push_back(want);
		endfunction

		// result beat: compare against the oldest owed result
		function void check_result(dq_out_t got);
			dq_out_t want;
			if (awaited.size() == 0) begin
				faults++;
				if (faults <= MAX_REPORT)
					$display("%0t: stray result beat data_out %h status %0d count %0d",
						$realtime, got.data_out, got.status, got.count);
				return;
			end
			want = awaited.pop_front();
			if (got.data_out !== want.data_out || got.status !== want.status ||
					got.count !== want.count) begin
				faults++;
				if (faults <= MAX_REPORT)
					$display("%0t: mismatch data_out %h/%h status %0d/%0d count %0d/%0d (exp/act)",
						$realtime, want.data_out, got.data_out, want.status, got.status,
						want.count, got.count);
			end
		endfunction
	endclass

	logic    clk       = 1'b0;
	logic    arst_n    = 1'b0;
	logic    in_valid  = 1'b0;
	logic    in_ready;
	dq_in_t  in_data   = '0;
	logic    out_valid;
	logic    out_ready = 1'b0;
	dq_out_t out_data;

	bit      calm      = 1'b0;   // last stretch: no idling on either side
	int      idle_pct  = 20;

	deque_scoreboard sb = new();

	double_ended_queue_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check_result(out_data);
	end

	// receiver: ready in random stretches, broken by random stalls
	initial begin
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (calm) begin
				out_ready <= 1'b1;
				@(posedge clk);
			end else if ($urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, ($urandom_range(0, 4) == 0) ? 40 : 8)) @(posedge clk);
			end
		end
	end

	function automatic word_t random_word();
		case ($urandom_range(0, 15))
			0:       return '0;
			1:       return '1;
			default: return $urandom;
		endcase
	endfunction

	// one command beat: optional sender gap, then hold until accepted
	task automatic send_beat(logic [2:0] command, word_t word);
		dq_in_t beat;
		beat.command = command;
		beat.data_in = word;
		if (!calm && $urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= beat;
		do @(posedge clk); while (!in_ready);
		sb.note_command(beat);
	endtask

	// empty-queue reads, both extremes of the data word, fill to full, pushes on a full queue, the unused code, clear
	task automatic run_directed();
		send_beat(CMD_POP_FRONT, random_word());
		send_beat(CMD_PEEK_BACK, random_word());
		send_beat(CMD_PUSH_FRONT, '1);
		send_beat(CMD_PUSH_BACK, '0);
		send_beat(CMD_PEEK_FRONT, random_word());
		send_beat(CMD_PEEK_BACK, random_word());
		send_beat(CMD_POP_BACK, random_word());
		send_beat(CMD_POP_FRONT, random_word());
		send_beat(CMD_POP_BACK, random_word());
		for (int i = 0; i < DEPTH; i++)
			send_beat((i % 2 == 0) ? CMD_PUSH_BACK : CMD_PUSH_FRONT, random_word());
		send_beat(CMD_PUSH_FRONT, random_word());
		send_beat(CMD_PUSH_BACK, random_word());
		send_beat(CMD_UNUSED, random_word());
		send_beat(CMD_CLEAR, random_word());
		send_beat(CMD_POP_FRONT, random_word());
	endtask

	// random episodes, each leaning toward filling, draining or neither
	task automatic run_random(int total);
		int         sent;
		int         span;
		int         push_pct;
		int         pick;
		bit         drained;
		logic [2:0] command;
		sent    = 0;
		drained = 1'b0;
		while (sent < total) begin
			span = $urandom_range(10, 60);
			case ($urandom_range(0, 2))
				0:       push_pct = 85;
				1:       push_pct = 50;
				default: push_pct = 15;
			endcase
			case ($urandom_range(0, 2))
				0:       idle_pct = 0;
				1:       idle_pct = 15;
				default: idle_pct = 40;
			endcase
			for (int i = 0; i < span && sent < total; i++) begin
				if (sent >= total - 80) calm = 1'b1;
				// hold off once mid-run until every owed result is back
				if (!drained && sent >= total / 2) begin
					drained  = 1'b1;
					in_valid <= 1'b0;
					do @(posedge clk); while (sb.awaited.size() != 0);
				end
				pick = $urandom_range(0, 99);
				if (pick < 2) begin
					command = CMD_CLEAR;
				end else if (pick < 4) begin
					command = CMD_UNUSED;
				end else if (pick < 4 + push_pct * 96 / 100) begin
					command = $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
				end else begin
					case ($urandom_range(0, 3))
						0:       command = CMD_POP_FRONT;
						1:       command = CMD_POP_BACK;
						2:       command = CMD_PEEK_FRONT;
						default: command = CMD_PEEK_BACK;
					endcase
				end
				send_beat(command, random_word());
				sent++;
			end
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		run_random(800);
		in_valid <= 1'b0;
		while (sb.awaited.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		$display("Covered %0d pushes, %0d pops, %0d peeks, %0d clears, %0d unused codes.",
			sb.seen_cmd[CMD_PUSH_FRONT] + sb.seen_cmd[CMD_PUSH_BACK],
			sb.seen_cmd[CMD_POP_FRONT] + sb.seen_cmd[CMD_POP_BACK],
			sb.seen_cmd[CMD_PEEK_FRONT] + sb.seen_cmd[CMD_PEEK_BACK],
			sb.seen_cmd[CMD_CLEAR], sb.seen_cmd[CMD_UNUSED]);
		$display("Pushes dropped on a full queue: %0d; reads of an empty queue: %0d; faults: %0d.",
			sb.seen_full, sb.seen_empty, sb.faults);
		if (sb.faults == 0 && sb.awaited.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

### sim.f
rtl/dq_pkg.sv
rtl/dq_cell.sv
rtl/double_ended_queue_core.sv
verif/double_ended_queue_core_test.sv
